// ===== design/xed_pkg.sv =====
// Shared types, constants and tables for the XML character reference decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package xed_pkg;

	localparam int MAX_PENDING = 8;
	localparam int IDX_W       = $clog2(MAX_PENDING);
	localparam int CNT_W       = $clog2(MAX_PENDING + 1);
	localparam int N_ENT       = 5;
	localparam int VAL_W       = 9;
	localparam int PROD_W      = 13;

	localparam logic [VAL_W-1:0] VAL_SAT = 9'd256;
	localparam logic [VAL_W-1:0] VAL_MAX = 9'd255;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;

	// named references: quot, amp, apos, lt, gt
	localparam logic [7:0] ENT_TEXT [N_ENT][4] = '{
		'{8'h71, 8'h75, 8'h6F, 8'h74},
		'{8'h61, 8'h6D, 8'h70, 8'h00},
		'{8'h61, 8'h70, 8'h6F, 8'h73},
		'{8'h6C, 8'h74, 8'h00, 8'h00},
		'{8'h67, 8'h74, 8'h00, 8'h00}
	};
	localparam logic [2:0] ENT_LEN  [N_ENT] = '{3'd4, 3'd3, 3'd4, 3'd2, 3'd2};
	localparam logic [7:0] ENT_CODE [N_ENT] = '{8'h22, 8'h26, 8'h27, 8'h3C, 8'h3E};

	typedef enum logic [2:0] {
		PH_TEXT     = 3'd0,
		PH_NAME     = 3'd1,
		PH_HASH     = 3'd2,
		PH_HEXSTART = 3'd3,
		PH_DIGITS   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_AMP  = 2'd1,
		S_HELD = 2'd2,
		S_BYTE = 2'd3
	} seq_state_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} hold_wr_t;

	typedef struct packed {
		logic             is_digit;
		logic [VAL_W-1:0] value;
	} acc_res_t;

endpackage

`default_nettype wire

// ===== design/xed_acc.sv =====
// Digit classifier and saturating multiply-accumulate for numeric references.
// Depends on xed_pkg.
`default_nettype none

module xed_acc import xed_pkg::*; (
	input  logic [VAL_W-1:0] value,
	input  logic             hex,
	input  logic [7:0]       ch,
	output acc_res_t         res
);

	logic [3:0]        dig;
	logic              is_d;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] sum;

	always_comb begin
		dig  = 4'd0;
		is_d = 1'b0;
		if (ch >= CH_0 && ch <= CH_9) begin
			is_d = 1'b1;
			dig  = 4'(ch - CH_0);
		end else if (hex && ch >= CH_LA && ch <= CH_LF) begin
			is_d = 1'b1;
			dig  = 4'(ch - CH_LA + 8'd10);
		end else if (hex && ch >= CH_UA && ch <= CH_UF) begin
			is_d = 1'b1;
			dig  = 4'(ch - CH_UA + 8'd10);
		end
		// x16 or x10 as shifts and one add
		prod = hex ? (PROD_W'(value) << 4)
		           : ((PROD_W'(value) << 3) + (PROD_W'(value) << 1));
		sum  = prod + PROD_W'(dig);
		res.is_digit = is_d;
		if (value >= VAL_SAT || sum > PROD_W'(VAL_SAT)) begin
			res.value = VAL_SAT;
		end else begin
			res.value = sum[VAL_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== design/xed_hold.sv =====
// Holding buffer for the bytes of an open reference, replayed on a flush.
// Depends on xed_pkg.
`default_nettype none

module xed_hold import xed_pkg::*; (
	input  logic             clk,
	input  hold_wr_t         wr,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [7:0]       rd_data
);

	logic [7:0] mem_q [MAX_PENDING];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// registered read; the caller presents the address of the next cycle
	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ===== design/xml_entity_decoder.sv =====
// Top level of the XML character reference decoder: reference parser, output
// sequencer and output register. Depends on xed_pkg, xed_acc and xed_hold.
`default_nettype none

// Takes one token byte per input beat and decodes &quot; &amp; &apos; &lt;
// &gt; &#DDD; and &#xHH; references; a reference that cannot complete comes
// out literally as '&' and its held bytes. A byte that is only held leaves
// the block ready for the next; a beat that produces output bytes (up to
// MAX_PENDING + 2 of them) is not followed by a new beat until the
// sequencer, which feeds the single output register one byte a cycle, has
// finished, as it holds in_ready low meanwhile. Back-pressure on the output
// stalls the sequencer and so holds up both the output bytes and new beats.
module xml_entity_decoder import xed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_last
);

	// parse state
	phase_t           phase_q, d_phase;
	logic [N_ENT-1:0] cand_q, d_cand, name_mask;
	logic             hex_q, d_hex;
	logic [VAL_W-1:0] val_q, d_val;
	logic [CNT_W-1:0] hcnt_q, d_hcnt;

	logic             d_hold, d_fail, d_text, d_emit, d_fl2, hold_ok;
	logic [7:0]       d_byte;
	logic [CNT_W-1:0] d_n2;
	logic             semi_hit;
	logic [7:0]       semi_code;

	acc_res_t         acc;
	hold_wr_t         hwr;
	logic [7:0]       hold_rd;

	// sequencer
	seq_state_t       state_q, state_d;
	logic             stage1_q, stage1_d;
	logic             bv_q, bv_d;
	logic [7:0]       b_q;
	logic             fl2_q, fl2_d;
	logic [CNT_W-1:0] n2_q, n2_d, fcnt_q, fcnt_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             last_q, last_d;

	logic             emit_vld, emit_fin, more_after, held_end;
	logic             out_free, accept, adv;
	logic [7:0]       emit_char;

	logic             out_valid_q, out_last_q;
	logic [7:0]       out_char_q;

	xed_acc u_acc (
		.value (val_q),
		.hex   (hex_q),
		.ch    (in_char),
		.res   (acc)
	);

	// read address is idx_d, the next idx_q, so the registered hold_rd matches idx_q
	xed_hold u_hold (
		.clk     (clk),
		.wr      (hwr),
		.rd_addr (idx_d),
		.rd_data (hold_rd)
	);

	assign hold_ok = hcnt_q < CNT_W'(MAX_PENDING);

	always_comb begin : name_match
		name_mask = '0;
		semi_hit  = 1'b0;
		semi_code = ENT_CODE[0];
		for (int i = 0; i < N_ENT; i++) begin
			name_mask[i] = cand_q[i] && (hcnt_q < CNT_W'(ENT_LEN[i])) &&
			               (ENT_TEXT[i][hcnt_q[1:0]] == in_char);
		end
		// lowest index wins on the closing ';'
		for (int i = N_ENT - 1; i >= 0; i--) begin
			if (cand_q[i] && hcnt_q == CNT_W'(ENT_LEN[i])) begin
				semi_hit  = 1'b1;
				semi_code = ENT_CODE[i];
			end
		end
	end

	always_comb begin : step_decode
		d_hold  = 1'b0;
		d_fail  = 1'b0;
		d_text  = 1'b0;
		d_emit  = 1'b0;
		d_byte  = in_char;
		d_phase = phase_q;
		d_cand  = cand_q;
		d_hex   = hex_q;
		d_val   = val_q;
		unique case (phase_q) inside
			PH_NAME: begin
				if (hcnt_q == '0 && in_char == CH_HASH) begin
					d_hold  = 1'b1;
					d_phase = PH_HASH;
				end else if (in_char == CH_SEMI) begin
					if (semi_hit) begin
						d_emit = 1'b1;
						d_byte = semi_code;
					end else begin
						d_fail = 1'b1;
					end
				end else if (name_mask != '0 && hold_ok) begin
					d_hold = 1'b1;
					d_cand = name_mask;
				end else begin
					d_fail = 1'b1;
				end
			end
			PH_HASH: begin
				if (in_char == CH_X) begin
					if (hold_ok) begin
						d_hold  = 1'b1;
						d_hex   = 1'b1;
						d_phase = PH_HEXSTART;
					end else begin
						d_fail = 1'b1;
					end
				end else if (acc.is_digit && hold_ok) begin
					d_hold  = 1'b1;
					d_hex   = 1'b0;
					d_val   = acc.value;
					d_phase = PH_DIGITS;
				end else begin
					d_fail = 1'b1;
				end
			end
			PH_HEXSTART, PH_DIGITS: begin
				if (in_char == CH_SEMI && phase_q == PH_DIGITS) begin
					if (val_q != '0 && val_q <= VAL_MAX) begin
						d_emit = 1'b1;
						d_byte = val_q[7:0];
					end else begin
						d_fail = 1'b1;
					end
				end else if (acc.is_digit && hold_ok) begin
					d_hold  = 1'b1;
					d_val   = acc.value;
					d_phase = PH_DIGITS;
				end else begin
					d_fail = 1'b1;
				end
			end
			default: begin
				d_text = 1'b1;
			end
		endcase

		if (d_fail) begin
			d_text = 1'b1;
		end
		d_hcnt = d_hold ? hcnt_q + 1'b1 : hcnt_q;

		// reference closes on a decode and on any byte taken as text
		if (d_emit || d_text) begin
			d_phase = PH_TEXT;
			d_cand  = '0;
			d_hex   = 1'b0;
			d_val   = '0;
			d_hcnt  = '0;
		end
		if (d_text) begin
			if (in_char == CH_AMP) begin
				d_phase = PH_NAME;
				d_cand  = '1;
			end else begin
				d_emit = 1'b1;
				d_byte = in_char;
			end
		end

		// token end with a reference still open: flush it as well
		d_fl2 = in_last && (d_phase != PH_TEXT);
		d_n2  = d_hcnt;
		if (d_fl2) begin
			d_phase = PH_TEXT;
			d_cand  = '0;
			d_hex   = 1'b0;
			d_val   = '0;
			d_hcnt  = '0;
		end
	end

	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign adv       = emit_vld && out_free;
	assign hwr.en    = accept && d_hold;
	assign hwr.addr  = hcnt_q[IDX_W-1:0];
	assign hwr.data  = in_char;

	assign more_after = stage1_q && (bv_q || fl2_q);
	assign held_end   = (CNT_W'(idx_q) + 1'b1) == fcnt_q;

	always_comb begin : seq_next
		state_d  = state_q;
		stage1_d = stage1_q;
		bv_d     = bv_q;
		fl2_d    = fl2_q;
		n2_d     = n2_q;
		fcnt_d   = fcnt_q;
		idx_d    = idx_q;
		last_d   = last_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					bv_d   = d_emit;
					fl2_d  = d_fl2;
					n2_d   = d_n2;
					last_d = in_last;
					idx_d  = '0;
					if (d_fail) begin
						state_d  = S_AMP;
						stage1_d = 1'b1;
						fcnt_d   = hcnt_q;
					end else if (d_emit) begin
						state_d = S_BYTE;
					end else if (d_fl2) begin
						state_d  = S_AMP;
						stage1_d = 1'b0;
						fcnt_d   = d_n2;
					end
				end
			end
			S_AMP, S_HELD: begin
				if (adv) begin
					if (state_q == S_AMP && fcnt_q != '0) begin
						state_d = S_HELD;
						idx_d   = '0;
					end else if (state_q == S_HELD && !held_end) begin
						idx_d = idx_q + 1'b1;
					end else if (more_after && bv_q) begin
						state_d  = S_BYTE;
						stage1_d = 1'b0;
					end else if (more_after) begin
						state_d  = S_AMP;
						stage1_d = 1'b0;
						fcnt_d   = n2_q;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_BYTE: begin
				if (adv) begin
					if (fl2_q) begin
						state_d  = S_AMP;
						stage1_d = 1'b0;
						fcnt_d   = n2_q;
						idx_d    = '0;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin : seq_out
		in_ready  = 1'b0;
		emit_vld  = 1'b0;
		emit_char = CH_AMP;
		emit_fin  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_AMP: begin
				emit_vld  = 1'b1;
				emit_char = CH_AMP;
				emit_fin  = (fcnt_q == '0) && !more_after;
			end
			S_HELD: begin
				emit_vld  = 1'b1;
				emit_char = hold_rd;
				emit_fin  = held_end && !more_after;
			end
			S_BYTE: begin
				emit_vld  = 1'b1;
				emit_char = b_q;
				emit_fin  = !fl2_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TEXT;
			cand_q      <= '0;
			hex_q       <= 1'b0;
			val_q       <= '0;
			hcnt_q      <= '0;
			state_q     <= S_IDLE;
			stage1_q    <= 1'b0;
			bv_q        <= 1'b0;
			fl2_q       <= 1'b0;
			n2_q        <= '0;
			fcnt_q      <= '0;
			idx_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= d_phase;
				cand_q  <= d_cand;
				hex_q   <= d_hex;
				val_q   <= d_val;
				hcnt_q  <= d_hcnt;
			end
			state_q  <= state_d;
			stage1_q <= stage1_d;
			bv_q     <= bv_d;
			fl2_q    <= fl2_d;
			n2_q     <= n2_d;
			fcnt_q   <= fcnt_d;
			idx_q    <= idx_d;
			last_q   <= last_d;
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			b_q <= d_byte;
		end
		if (adv) begin
			out_char_q <= emit_char;
			out_last_q <= last_q && emit_fin;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_hcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q <= CNT_W'(MAX_PENDING))
		else $error("held count beyond buffer depth");

	a_val_sat: assert property (@(posedge clk) disable iff (!arst_n)
		val_q <= VAL_SAT)
		else $error("number value beyond saturation");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HELD) |-> (CNT_W'(idx_q) < fcnt_q))
		else $error("flush reads past the held bytes");

	a_text_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TEXT) |-> (hcnt_q == '0 && cand_q == '0 && val_q == '0))
		else $error("parse state left over outside a reference");
`endif

endmodule

`default_nettype wire

// ===== test/xed_decode_check.sv =====
`timescale 1ns / 100ps
// Output checker for xml_entity_decoder: watches both channels, predicts the
// decoded byte stream and compares it beat by beat. Depends on xed_pkg.

module xed_decode_check import xed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_char,
	input  logic       out_last,
	output int         mismatches,
	output int         bytes_due
);

	localparam logic [7:0] AMP   = "&";
	localparam logic [7:0] SEMI  = ";";
	localparam logic [7:0] HASH  = "#";
	localparam logic [7:0] LOW_X = "x";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} out_byte_t;

	string      ref_names [5] = '{"quot", "amp", "apos", "lt", "gt"};
	logic [7:0] ref_codes [5] = '{"\"", "&", "'", "<", ">"};

	// predictor state
	phase_t     ref_phase;
	logic [4:0] name_match;
	logic       hex_ref;
	int         num_acc;
	logic [7:0] held [MAX_PENDING];
	int         held_n;

	logic [7:0] decoded [$];
	out_byte_t  expected_bytes [$];

	initial mismatches = 0;
	initial bytes_due = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: decode mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic end_reference();
		ref_phase  = PH_TEXT;
		name_match = '0;
		hex_ref    = 1'b0;
		num_acc    = 0;
		held_n     = 0;
	endtask

	task automatic text_byte(input logic [7:0] c);
		if (c == AMP) begin
			ref_phase  = PH_NAME;
			name_match = 5'h1F;
			hex_ref    = 1'b0;
			num_acc    = 0;
			held_n     = 0;
		end else begin
			decoded.push_back(c);
		end
	endtask

	task automatic spill_held();
		decoded.push_back(AMP);
		for (int i = 0; i < held_n; i++)
			decoded.push_back(held[i]);
		end_reference();
	endtask

	// reference cannot go on: out it comes literally, then the byte as text
	task automatic give_up(input logic [7:0] c);
		spill_held();
		text_byte(c);
	endtask

	task automatic keep_byte(input logic [7:0] c);
		held[held_n] = c;
		held_n++;
	endtask

	function automatic int digit_val(input logic [7:0] c, input logic hex);
		if (c >= "0" && c <= "9")
			return int'(c) - int'("0");
		if (hex && c >= "a" && c <= "f")
			return int'(c) - int'("a") + 10;
		if (hex && c >= "A" && c <= "F")
			return int'(c) - int'("A") + 10;
		return 16;
	endfunction

	// saturates at 256, which is already out of range
	task automatic push_digit(input int d);
		if (num_acc < 256) begin
			num_acc = num_acc * (hex_ref ? 16 : 10) + d;
			if (num_acc > 256)
				num_acc = 256;
		end
	endtask

	task automatic decode_beat(input logic [7:0] c, input logic last);
		int        hit;
		int        d;
		logic [4:0] mask;
		out_byte_t b;
		decoded.delete();
		case (ref_phase)
		PH_NAME: begin
			if (held_n == 0 && c == HASH) begin
				keep_byte(c);
				ref_phase = PH_HASH;
			end else if (c == SEMI) begin
				hit = -1;
				for (int i = 0; i < 5; i++)
					if (hit < 0 && name_match[i] && ref_names[i].len() == held_n)
						hit = i;
				if (hit >= 0) begin
					decoded.push_back(ref_codes[hit]);
					end_reference();
				end else begin
					give_up(c);
				end
			end else begin
				mask = '0;
				for (int i = 0; i < 5; i++)
					if (name_match[i] && held_n < ref_names[i].len() &&
					    ref_names[i][held_n] == c)
						mask[i] = 1'b1;
				if (mask != '0 && held_n < MAX_PENDING) begin
					keep_byte(c);
					name_match = mask;
				end else begin
					give_up(c);
				end
			end
		end
		PH_HASH: begin
			d = digit_val(c, 1'b0);
			if (c == LOW_X) begin
				if (held_n < MAX_PENDING) begin
					keep_byte(c);
					hex_ref   = 1'b1;
					ref_phase = PH_HEXSTART;
				end else begin
					give_up(c);
				end
			end else if (d < 16 && held_n < MAX_PENDING) begin
				keep_byte(c);
				hex_ref = 1'b0;
				push_digit(d);
				ref_phase = PH_DIGITS;
			end else begin
				give_up(c);
			end
		end
		PH_HEXSTART, PH_DIGITS: begin
			d = digit_val(c, hex_ref);
			if (c == SEMI && ref_phase == PH_DIGITS) begin
				if (num_acc >= 1 && num_acc <= 255) begin
					decoded.push_back(num_acc[7:0]);
					end_reference();
				end else begin
					give_up(c);
				end
			end else if (d < 16 && held_n < MAX_PENDING) begin
				keep_byte(c);
				push_digit(d);
				ref_phase = PH_DIGITS;
			end else begin
				give_up(c);
			end
		end
		default: begin
			end_reference();
			text_byte(c);
		end
		endcase

		if (last && ref_phase != PH_TEXT)
			spill_held();
		foreach (decoded[i]) begin
			b.ch   = decoded[i];
			b.last = last && (i == decoded.size() - 1);
			expected_bytes.push_back(b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_byte_t want;
		if (!arst_n) begin
			end_reference();
			expected_bytes.delete();
			bytes_due <= 0;
		end else begin
			if (in_valid && in_ready)
				decode_beat(in_char, in_last);
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected beat, out_char %02h out_last %0b",
						out_char, out_last));
				end else begin
					want = expected_bytes.pop_front();
					if (out_char !== want.ch)
						report_mismatch($sformatf("out_char %02h, expected %02h",
							out_char, want.ch));
					if (out_last !== want.last)
						report_mismatch($sformatf("out_last %0b, expected %0b (char %02h)",
							out_last, want.last, want.ch));
				end
			end
			bytes_due <= expected_bytes.size();
		end
	end

endmodule

// ===== test/xml_entity_decoder_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for xml_entity_decoder: drives text tokens full of character
// references and gives the verdict. Depends on the block and xed_decode_check.

module xml_entity_decoder_tb;

	localparam int RANDOM_BEATS = 410;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE       = 40;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_char   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       out_last;
	int         mismatches;
	int         bytes_due;
	int         tx_idle_pct = 32;
	int         rx_idle_pct = 56;

	string ref_names [5] = '{"quot", "amp", "apos", "lt", "gt"};
	// malformed numeric and named forms, strtol leniencies among them
	string odd_refs [16] = '{"&#;", "&#x;", "&#0;", "&#x00;", "&#256;", "&#X41;",
		"&# 9;", "&#-5;", "&#x+a;", "&#65536;", "&#000000065;", "&#0x41;",
		"&AMP;", "&;", "&ltt;", "&quo;"};

	xml_entity_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_char   (in_char),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.out_last  (out_last)
	);

	xed_decode_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.out_last   (out_last),
		.mismatches (mismatches),
		.bytes_due  (bytes_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// one beat per byte, in_last on the final one
	task automatic send_token(input string s);
		for (int i = 0; i < s.len(); i++) begin
			while ($urandom_range(0, 99) < tx_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_char  <= s[i];
			in_last  <= (i == s.len() - 1);
			do @(posedge clk); while (!in_ready);
		end
	endtask

	function automatic string tricky_byte();
		string pool;
		int    k;
		pool = "&#;x09afAFXqumplsgt";
		if ($urandom_range(0, 3) == 0)
			return $sformatf("%c", $urandom_range(1, 255));
		k = $urandom_range(0, pool.len() - 1);
		return pool.substr(k, k);
	endfunction

	function automatic string well_formed_ref();
		string pad;
		string h;
		pad = "";
		case ($urandom_range(0, 9))
		0:       pad = "0";
		1: begin
			repeat ($urandom_range(2, 6))
				pad = {pad, "0"};
		end
		default: pad = "";
		endcase
		case ($urandom_range(0, 3))
		0, 1: return {"&", ref_names[$urandom_range(0, 4)], ";"};
		2:    return {"&#", pad, $sformatf("%0d", $urandom_range(1, 255)), ";"};
		default: begin
			h = $sformatf("%0h", $urandom_range(1, 255));
			if ($urandom_range(0, 1))
				h = h.toupper();
			return {"&#x", pad, h, ";"};
		end
		endcase
	endfunction

	function automatic string make_token();
		string s;
		string seg;
		int    cut;
		s = "";
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 9))
			0, 1:       seg = $sformatf("%c", $urandom_range(1, 255));
			2, 3, 4, 5: seg = well_formed_ref();
			6:          seg = odd_refs[$urandom_range(0, 15)];
			7, 8: begin
				seg = well_formed_ref();
				cut = $urandom_range(1, seg.len() - 1);
				seg = {seg.substr(0, cut - 1), tricky_byte()};
			end
			default: begin
				seg = tricky_byte();
				if ($urandom_range(0, 1))
					seg = {seg, tricky_byte()};
			end
			endcase
			s = {s, seg};
		end
		return s;
	endfunction

	initial begin
		string tok;
		int    sent;
		int    spin;
		sent = 0;
		spin = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes, failed '&' reopening, empty and saturated numbers,
		// too many held bytes on the final beat, token ending mid-reference
		send_token("\001&gt;\377");
		send_token("&&#;");
		send_token("&#xfF;");
		send_token("&#9999;");
		send_token("&#00000001");
		send_token("&am");

		while (sent < RANDOM_BEATS) begin
			if (sent >= RANDOM_BEATS / 3 && tx_idle_pct == 32) begin
				// hold off until the output has fully drained
				in_valid <= 1'b0;
				do @(posedge clk); while (bytes_due != 0);
				tx_idle_pct <= 56;
				rx_idle_pct <= 32;
			end else if (sent >= 2 * RANDOM_BEATS / 3 && tx_idle_pct != 0) begin
				tx_idle_pct <= 0;
				rx_idle_pct <= 0;
			end
			tok = make_token();
			send_token(tok);
			sent += tok.len();
		end
		in_valid <= 1'b0;

		do begin
			@(posedge clk);
			spin++;
		end while (bytes_due != 0 && spin < DRAIN_LIMIT);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && bytes_due == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/xed_pkg.sv
design/xed_acc.sv
design/xed_hold.sv
design/xml_entity_decoder.sv
test/xed_decode_check.sv
test/xml_entity_decoder_tb.sv
